// ===== sv/tbpc_pkg.sv =====
// Shared types and constants of the two-button press classifier.
`default_nettype none
package tbpc_pkg;

	// Depth of the event ring; one slot always stays empty.
	localparam int FIFO_SLOTS = 4;
	localparam int PTR_W      = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;

	// Depth of the command queue between the front and the back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

	localparam logic [31:0] LONG_PRESS_RESET = 32'd5000;

	localparam logic KIND_SAMPLE  = 1'b0;
	localparam logic KIND_POP     = 1'b1;
	localparam logic BUTTON_RED   = 1'b0;
	localparam logic BUTTON_GREEN = 1'b1;
	localparam logic TYPE_SHORT   = 1'b0;
	localparam logic TYPE_LONG    = 1'b1;

	typedef struct packed {
		logic ev_type;
		logic button;
	} event_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic   is_pop;
		logic   push0_valid;
		event_t push0;
		logic   push1_valid;
		event_t push1;
		logic   red_held;
		logic   green_held;
	} cmd_t;

endpackage
`default_nettype wire

// ===== sv/tbpc_chan_if.sv =====
// Valid/ready channel interfaces for the sample and result sides.
`default_nettype none
interface tbpc_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] now_ms;
	logic        red_pin_level;
	logic        green_pin_level;

	modport source (output valid, kind, now_ms, red_pin_level, green_pin_level,
		input ready);
	modport sink (input valid, kind, now_ms, red_pin_level, green_pin_level,
		output ready);
endinterface

interface tbpc_out_if;
	logic valid;
	logic ready;
	logic event_valid;
	logic event_button;
	logic event_type;
	logic red_held;
	logic green_held;

	modport source (output valid, event_valid, event_button, event_type, red_held,
		green_held, input ready);
	modport sink (input valid, event_valid, event_button, event_type, red_held,
		green_held, output ready);
endinterface
`default_nettype wire

// ===== sv/two_button_press_classifier_top.sv =====
// Top level of the two-button press classifier with its event ring.
// On its way to the result, each item is first registered by the command queue, and then
// the back's output register takes it.
// One item per cycle while the command queue has room; when it is full, ready drops.
// Reset (arst_n, asynchronous, active low): both buttons released, ring empty,
// long-press time 5000 ms; the ring contents themselves are not cleared.
`default_nettype none
module two_button_press_classifier_top
	import tbpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tbpc_in_if.sink     in_ch,
	tbpc_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// The front updates the red and then the green button on every sample transfer
	// and turns each transfer into a command: either a pop, or up to two events to
	// be queued in order, and each command carries the held state of both buttons.
	logic cmd_push, cmd_full, cmd_not_empty, cmd_pop;
	cmd_t cmd_in, cmd_out;

	tbpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_in),
		.cmd_full  (cmd_full)
	);

	// The command queue lets the front keep taking transfers while a result is
	// waiting for the sink, and lets the back stall without holding up the front
	// until the queue is full.
	tbpc_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.not_empty (cmd_not_empty),
		.pop_data  (cmd_out)
	);

	// The back applies commands strictly in order to the event ring, so every pop
	// sees exactly the events that the samples before it queued, and it presents
	// each result from its output register.
	tbpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_not_empty),
		.cmd_data  (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

// ===== sv/tbpc_front.sv =====
// Front part: button tracking, long-press register and item classification.
`default_nettype none
module tbpc_front
	import tbpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tbpc_in_if.sink     in_ch,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        cmd_push,
	output cmd_t        cmd_data,
	input  logic        cmd_full
);

	typedef struct packed {
		logic        down;
		logic        long_done;
		logic [31:0] start;
		logic        push_valid;
		logic        push_type;
	} btn_upd_t;

	// Next state of one button for a sample, and the event it raises if any.
	function automatic btn_upd_t track_btn(input logic level, input logic [31:0] now,
		input logic down, input logic long_done, input logic [31:0] start,
		input logic [31:0] hold_lim);
		btn_upd_t    u;
		logic        press;
		logic        release_n;
		logic [31:0] held_for;
		press     = !level && !down;
		release_n = level && down;
		u.down    = !level;
		u.start   = press ? now : start;
		u.long_done = (press || release_n) ? 1'b0 : long_done;
		u.push_valid = release_n && !long_done;
		u.push_type  = TYPE_SHORT;
		held_for = now - u.start;
		if (u.down && !u.long_done && (held_for >= hold_lim)) begin
			u.long_done  = 1'b1;
			u.push_valid = 1'b1;
			u.push_type  = TYPE_LONG;
		end
		return u;
	endfunction

	logic        red_down_q, red_long_done_q, green_down_q, green_long_done_q;
	logic [31:0] red_start_q, green_start_q, long_press_q;
	logic        accept, sample;
	btn_upd_t    red_upd, green_upd;

	assign in_ch.ready = !cmd_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign sample      = accept && (in_ch.kind == KIND_SAMPLE);
	assign cmd_push    = accept;

	assign red_upd = track_btn(in_ch.red_pin_level, in_ch.now_ms, red_down_q,
		red_long_done_q, red_start_q, long_press_q);
	assign green_upd = track_btn(in_ch.green_pin_level, in_ch.now_ms, green_down_q,
		green_long_done_q, green_start_q, long_press_q);

	always_comb begin
		cmd_data.is_pop        = (in_ch.kind == KIND_POP);
		cmd_data.push0_valid   = !cmd_data.is_pop && red_upd.push_valid;
		cmd_data.push0.button  = BUTTON_RED;
		cmd_data.push0.ev_type = red_upd.push_type;
		cmd_data.push1_valid   = !cmd_data.is_pop && green_upd.push_valid;
		cmd_data.push1.button  = BUTTON_GREEN;
		cmd_data.push1.ev_type = green_upd.push_type;
		cmd_data.red_held      = cmd_data.is_pop ? red_down_q : red_upd.down;
		cmd_data.green_held    = cmd_data.is_pop ? green_down_q : green_upd.down;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_down_q        <= 1'b0;
			red_long_done_q   <= 1'b0;
			red_start_q       <= '0;
			green_down_q      <= 1'b0;
			green_long_done_q <= 1'b0;
			green_start_q     <= '0;
			long_press_q      <= LONG_PRESS_RESET;
		end else begin
			if (cfg_we) begin
				long_press_q <= cfg_wdata;
			end
			if (sample) begin
				red_down_q        <= red_upd.down;
				red_long_done_q   <= red_upd.long_done;
				red_start_q       <= red_upd.start;
				green_down_q      <= green_upd.down;
				green_long_done_q <= green_upd.long_done;
				green_start_q     <= green_upd.start;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tbpc_cmd_queue.sv =====
// Short command queue that decouples the front from the back.
`default_nettype none
module tbpc_cmd_queue
	import tbpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_data
);

	cmd_t                entry_q [CMDQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                do_push, do_pop;

	function automatic logic [CQ_PTR_W-1:0] next_ptr(input logic [CQ_PTR_W-1:0] p);
		return (p == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
	endfunction

	assign full      = (count_q == CQ_CNT_W'(CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CQ_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/tbpc_back.sv =====
// Back part: event ring, pops and the result output register.
`default_nettype none
module tbpc_back
	import tbpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd_data,
	output logic       cmd_pop,
	tbpc_out_if.source out_ch
);

	event_t             store_q [FIFO_SLOTS];
	logic [PTR_W-1:0]   wp_q, rp_q, wp_a, wp_b;
	logic               out_valid_q, event_valid_q, event_button_q, event_type_q;
	logic               red_held_q, green_held_q;
	logic               take, we0, we1, pop_hit;
	event_t             rd_ev;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_SLOTS - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign take    = cmd_valid && (!out_valid_q || out_ch.ready);
	assign cmd_pop = take;
	assign rd_ev   = store_q[rp_q];
	assign pop_hit = take && cmd_data.is_pop && (wp_q != rp_q);

	// Red's event goes in first; green's sees the ring as red left it.
	always_comb begin
		we0  = 1'b0;
		we1  = 1'b0;
		wp_a = wp_q;
		if (take && !cmd_data.is_pop && cmd_data.push0_valid &&
				(next_ptr(wp_q) != rp_q)) begin
			we0  = 1'b1;
			wp_a = next_ptr(wp_q);
		end
		wp_b = wp_a;
		if (take && !cmd_data.is_pop && cmd_data.push1_valid &&
				(next_ptr(wp_a) != rp_q)) begin
			we1  = 1'b1;
			wp_b = next_ptr(wp_a);
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			store_q[wp_q] <= cmd_data.push0;
		end
		if (we1) begin
			store_q[wp_a] <= cmd_data.push1;
		end
		if (take) begin
			event_valid_q  <= pop_hit;
			event_button_q <= pop_hit ? rd_ev.button : 1'b0;
			event_type_q   <= pop_hit ? rd_ev.ev_type : 1'b0;
			red_held_q     <= cmd_data.red_held;
			green_held_q   <= cmd_data.green_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wp_q <= wp_b;
			if (pop_hit) begin
				rp_q <= next_ptr(rp_q);
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_valid  = event_valid_q;
	assign out_ch.event_button = event_button_q;
	assign out_ch.event_type   = event_type_q;
	assign out_ch.red_held     = red_held_q;
	assign out_ch.green_held   = green_held_q;

`ifndef ASSERT_OFF
	a_empty_pop_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_data.is_pop && (wp_q == rp_q) |=> out_valid_q && !event_valid_q)
		else $error("pop on an empty ring returned an event");
	a_sample_keeps_rp: assert property (@(posedge clk) disable iff (!arst_n)
		take && !cmd_data.is_pop |=> $stable(rp_q))
		else $error("sample moved the read pointer");
	a_pop_keeps_wp: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_data.is_pop |=> $stable(wp_q))
		else $error("pop moved the write pointer");
	a_ring_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		we0 || we1 |=> (wp_q != rp_q))
		else $error("push left the ring looking empty");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the two-button press classifier and its event ring.
`timescale 1ns / 100ps
module tb
	import tbpc_pkg::*;
();

	// The result that one transfer on the input channel should produce.
	typedef struct packed {
		logic ev_valid;
		logic ev_button;
		logic ev_type;
		logic red_held;
		logic green_held;
	} press_result_t;

	// Shadow of the classifier: tracks both buttons and the event ring, and
	// holds the results that are still owed by the block, oldest first.
	class press_scoreboard;
		logic [31:0]   hold_limit;
		logic          down [2];
		logic          long_done [2];
		logic [31:0]   start_ms [2];
		event_t        ring [FIFO_SLOTS];
		int unsigned   wr_idx;
		int unsigned   rd_idx;
		press_result_t owed [$];
		int            errors;

		function void reset_state();
			hold_limit = LONG_PRESS_RESET;
			for (int b = 0; b < 2; b++) begin
				down[b]      = 1'b0;
				long_done[b] = 1'b0;
				start_ms[b]  = '0;
			end
			wr_idx = 0;
			rd_idx = 0;
			errors = 0;
			owed.delete();
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// A full ring (one slot always free) silently drops the new event.
		function void push_event(logic button, logic ev_type);
			int unsigned nxt;
			nxt = (wr_idx + 1) % FIFO_SLOTS;
			if (nxt == rd_idx)
				return;
			ring[wr_idx].button  = button;
			ring[wr_idx].ev_type = ev_type;
			wr_idx = nxt;
		endfunction

		function void track_button(int b, logic level, logic [31:0] now);
			logic btn;
			logic [31:0] held;
			btn = (b == 0) ? BUTTON_RED : BUTTON_GREEN;
			if (!level && !down[b]) begin
				down[b]      = 1'b1;
				start_ms[b]  = now;
				long_done[b] = 1'b0;
			end
			if (level && down[b]) begin
				if (!long_done[b])
					push_event(btn, TYPE_SHORT);
				down[b]      = 1'b0;
				long_done[b] = 1'b0;
			end
			held = now - start_ms[b];
			if (down[b] && !long_done[b] && held >= hold_limit) begin
				long_done[b] = 1'b1;
				push_event(btn, TYPE_LONG);
			end
		endfunction

		function void note_item(logic kind, logic [31:0] now, logic red, logic green);
			press_result_t r;
			r = '0;
			if (kind == KIND_SAMPLE) begin
				track_button(0, red, now);
				track_button(1, green, now);
			end else if (wr_idx != rd_idx) begin
				r.ev_valid  = 1'b1;
				r.ev_button = ring[rd_idx].button;
				r.ev_type   = ring[rd_idx].ev_type;
				rd_idx = (rd_idx + 1) % FIFO_SLOTS;
			end
			r.red_held   = down[0];
			r.green_held = down[1];
			owed.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(press_result_t got);
			press_result_t want;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("result %b arrived with none outstanding", got));
				return;
			end
			want = owed.pop_front();
			if (got.ev_valid !== want.ev_valid)
				report_mismatch($sformatf("event_valid %b, expected %b",
					got.ev_valid, want.ev_valid));
			if (got.ev_button !== want.ev_button)
				report_mismatch($sformatf("event_button %b, expected %b",
					got.ev_button, want.ev_button));
			if (got.ev_type !== want.ev_type)
				report_mismatch($sformatf("event_type %b, expected %b",
					got.ev_type, want.ev_type));
			if (got.red_held !== want.red_held)
				report_mismatch($sformatf("red_held %b, expected %b",
					got.red_held, want.red_held));
			if (got.green_held !== want.green_held)
				report_mismatch($sformatf("green_held %b, expected %b",
					got.green_held, want.green_held));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	tbpc_in_if  in_ch ();
	tbpc_out_if out_ch ();

	two_button_press_classifier_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	press_scoreboard store;
	press_result_t   seen;

	// While steady is set neither side inserts any idle cycles.
	logic        steady;
	// Stimulus-side view of the pins, the current time and the time each
	// button was last pressed; the last lets holds land right on the limit.
	logic        pin_lvl [2];
	logic [31:0] clock_ms;
	logic [31:0] press_at [2];
	logic [31:0] hold_ms;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Any hang ends the run here, well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// The result side stalls about a quarter of the time, except during the
	// steady stretch. Ready is changed only on the falling edge.
	initial out_ch.ready = 1'b0;
	always @(negedge clk)
		out_ch.ready <= steady || ($urandom_range(99) >= 24);

	// Every result transfer is checked against the oldest outstanding one.
	// Sampling on the rising edge sees the values from before the edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen.ev_valid   = out_ch.event_valid;
			seen.ev_button  = out_ch.event_button;
			seen.ev_type    = out_ch.event_type;
			seen.red_held   = out_ch.red_held;
			seen.green_held = out_ch.green_held;
			store.check_result(seen);
		end
	end

	// Offers one item and returns at the falling edge after its transfer, with
	// valid still high so that back-to-back items keep the channel busy.
	// Random idle cycles ahead of the item drop valid for a while.
	task automatic send_item(input logic kind, input logic [31:0] now,
		input logic red, input logic green);
		while (!steady && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.kind            <= kind;
		in_ch.now_ms          <= now;
		in_ch.red_pin_level   <= red;
		in_ch.green_pin_level <= green;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		store.note_item(kind, now, red, green);
		@(negedge clk);
	endtask

	// A sample tick with the given pin levels; a level falling from high to
	// low is a new press, and its time is remembered for later holds.
	task automatic sample(input logic [31:0] now, input logic red, input logic green);
		if (pin_lvl[0] && !red)
			press_at[0] = now;
		if (pin_lvl[1] && !green)
			press_at[1] = now;
		pin_lvl[0] = red;
		pin_lvl[1] = green;
		clock_ms = now;
		send_item(KIND_SAMPLE, now, red, green);
	endtask

	// A pop carries random time and pin bits, which the block must ignore.
	task automatic pop_event();
		send_item(KIND_POP, $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// The long-press time is only changed once every owed result has come back
	// and the channel is quiet.
	task automatic set_hold(input logic [31:0] ms);
		in_ch.valid <= 1'b0;
		while (store.pending() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ms;
		@(negedge clk);
		cfg_we  <= 1'b0;
		hold_ms = ms;
		store.hold_limit = ms;
	endtask

	// Next sample time: mostly small steps, often a hold just short of, at or
	// just past the limit for one of the buttons, sometimes a jump anywhere so
	// that every bit of the time field and the wrap of the counter are seen.
	function automatic logic [31:0] next_time();
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		span = (hold_ms > 32'd2000) ? 2000 : hold_ms;
		if (pick < 35)
			return clock_ms + $urandom_range(3);
		if (pick < 65)
			return press_at[1'($urandom_range(1))] + hold_ms - 32'd1 + $urandom_range(2);
		if (pick < 90)
			return clock_ms + $urandom_range(span);
		return $urandom();
	endfunction

	// Press and release sequences with random timing; each pin flips now and
	// then, so presses are held across several ticks before release.
	task automatic random_sample();
		logic red;
		logic green;
		red   = pin_lvl[0] ^ ($urandom_range(99) < 30);
		green = pin_lvl[1] ^ ($urandom_range(99) < 30);
		sample(next_time(), red, green);
	endtask

	task automatic run_random(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 28)
				pop_event();
			else
				random_sample();
		end
	endtask

	initial begin
		logic [31:0] limits [6];

		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		in_ch.valid           = 1'b0;
		in_ch.kind            = KIND_SAMPLE;
		in_ch.now_ms          = '0;
		in_ch.red_pin_level   = 1'b1;
		in_ch.green_pin_level = 1'b1;
		steady                = 1'b0;
		pin_lvl[0]            = 1'b1;
		pin_lvl[1]            = 1'b1;
		press_at[0]           = '0;
		press_at[1]           = '0;
		clock_ms              = '0;
		hold_ms               = LONG_PRESS_RESET;
		store = new;
		store.reset_state();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the long-press time left at its reset value.
		// A pop straight after reset finds the ring empty.
		pop_event();
		sample(32'd0, 1'b1, 1'b1);
		// A quick red tap gives a short press.
		sample(32'd100, 1'b0, 1'b1);
		sample(32'd200, 1'b1, 1'b1);
		// Green held one millisecond short of the limit, then exactly on it;
		// it is reported once only, and its release adds nothing.
		sample(32'd300, 1'b1, 1'b0);
		sample(32'd5299, 1'b1, 1'b0);
		sample(32'd5300, 1'b1, 1'b0);
		sample(32'd9000, 1'b1, 1'b0);
		sample(32'd9001, 1'b1, 1'b1);
		pop_event();
		pop_event();
		pop_event();
		// Two double taps produce four shorts; the ring holds three, so the
		// last green one is dropped.
		sample(32'd10000, 1'b0, 1'b0);
		sample(32'd10001, 1'b1, 1'b1);
		sample(32'd10002, 1'b0, 1'b0);
		sample(32'd10003, 1'b1, 1'b1);
		pop_event();
		pop_event();
		pop_event();
		pop_event();
		// A red hold across the wrap of the millisecond counter.
		sample(32'hFFFF_FF00, 1'b0, 1'b1);
		sample(32'h0000_1287, 1'b0, 1'b1);
		sample(32'h0000_1288, 1'b0, 1'b1);
		sample(32'hFFFF_FFFF, 1'b1, 1'b1);
		pop_event();

		// With a zero hold time a press is reported as long on the very tick
		// it is seen, for both buttons in the same tick too.
		set_hold(32'd0);
		sample(32'd50, 1'b0, 1'b1);
		sample(32'd51, 1'b1, 1'b1);
		sample(32'd52, 1'b0, 1'b0);
		sample(32'd53, 1'b1, 1'b1);
		pop_event();
		pop_event();
		pop_event();

		// Random phases over a range of hold times, extremes included. The
		// phase with the one-millisecond limit runs with no idling at all.
		limits[0] = 32'd0;
		limits[1] = 32'd1;
		limits[2] = 32'hFFFF_FFFF;
		limits[3] = $urandom_range(300, 2);
		limits[4] = LONG_PRESS_RESET;
		limits[5] = $urandom();
		for (int p = 0; p < 6; p++) begin
			set_hold(limits[p]);
			steady = (p == 1);
			run_random(88);
		end
		steady = 1'b0;

		// Let every owed result come back, then keep watching for anything
		// the block might still emit.
		in_ch.valid <= 1'b0;
		while (store.pending() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (store.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
